// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge out of reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/ffha_pkg.sv =====
// package for the first-fit heap allocator: codes, states, ctrl/dp structs
// no dependencies
package ffha_pkg;
  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_ZERO  = 3'd1;
  localparam logic [2:0] ST_NOFIT = 3'd2;
  localparam logic [2:0] ST_BAD   = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  localparam logic [31:0] HEAP_SIZE_RESET = 32'd20971520;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_SCAN, S_RD, S_DECIDE, S_SHL, S_SHR, S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture command
    logic clr;      // clear table (init)
    logic scan;     // scan phase: the entry at the scan index is read
    logic rd;       // test the entry just read
    logic decide;   // apply the decision
    logic shl;      // one step of a left shift
    logic shr;      // one step of a right shift
    logic done;     // emit result
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic scan_end;   // scan finished
    logic need_shl;
    logic need_shr;
    logic shift_end;
    logic bad_early;  // result known without scan
  } stat_t;
endpackage

// ===== src/ffha_ctrl.sv =====
// controller state machine of the heap allocator
// depends on ffha_pkg
module ffha_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  ffha_pkg::stat_t st,
  output ffha_pkg::ctrl_t ctl,
  output logic            busy
);
  import ffha_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (start) state_nxt = S_CLR;
      S_CLR:    state_nxt = st.bad_early ? S_DONE : S_SCAN;
      S_SCAN:   state_nxt = S_RD;
      S_RD:     state_nxt = st.scan_end ? S_DECIDE : S_SCAN;
      S_DECIDE: begin
        if (st.need_shl) state_nxt = S_SHL;
        else if (st.need_shr) state_nxt = S_SHR;
        else state_nxt = S_DONE;
      end
      S_SHL:    if (st.shift_end) state_nxt = S_DONE;
      S_SHR:    if (st.shift_end) state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_IDLE:   ctl.load = start;
      S_CLR:    ctl.clr = 1'b1;
      S_SCAN:   ctl.scan = 1'b1;
      S_RD:     ctl.rd = 1'b1;
      S_DECIDE: ctl.decide = 1'b1;
      S_SHL:    ctl.shl = 1'b1;
      S_SHR:    ctl.shr = 1'b1;
      S_DONE:   ctl.done = 1'b1;
      default:  ctl = '0;
    endcase
  end
endmodule

// ===== src/ffha_dp.sv =====
// datapath of the heap allocator: extent memory, scan, shift, arithmetic
// depends on ffha_pkg
module ffha_dp #(
  parameter int FREE_SLOTS = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ffha_pkg::ctrl_t ctl,
  input  logic [1:0]      cmd,
  input  logic [31:0]     size_bytes,
  input  logic [31:0]     address,
  input  logic [31:0]     heap_base,
  input  logic [30:0]     heap_size,
  output ffha_pkg::stat_t st,
  output logic [2:0]      status,
  output logic [31:0]     block_address,
  output logic [31:0]     free_bytes
);
  import ffha_pkg::*;
  localparam int IW = $clog2(FREE_SLOTS);
  localparam int CW = $clog2(FREE_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS = CW'(FREE_SLOTS);

  // one memory holding start and length
  logic [63:0] mem [FREE_SLOTS];
  logic [63:0] rdata_r;
  logic        we;
  logic [IW-1:0] waddr, raddr;
  logic [63:0] wdata;

  logic [1:0]  cmd_r;
  logic [31:0] addr_r;
  logic [32:0] need_r, end_r;
  logic [CW-1:0] count_r, idx_r, pos_r, sh_r;
  logic [31:0] free_r, blk_r;
  logic [2:0]  stat_r;
  logic        found_r, bad_r;
  logic [32:0] prev_top_r;
  logic [31:0] prev_len_r;
  logic        has_prev_r;
  logic [63:0] carry_r;
  logic        rd_v_r;

  wire [31:0] e_start = rdata_r[63:32];
  wire [31:0] e_len   = rdata_r[31:0];
  wire [32:0] rnd = {1'b0, size_bytes} + 33'd7;
  wire [32:0] round8 = {rnd[32:3], 3'b000};
  wire [33:0] heap_top = {2'b0, heap_base} + {3'b0, heap_size};

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  // shifts read one entry ahead of the write
  always_comb begin
    raddr = idx_r[IW-1:0];
    if (ctl.shl) raddr = rd_v_r ? IW'(sh_r + CW'(1)) : sh_r[IW-1:0];
    if (ctl.shr) raddr = rd_v_r ? IW'(sh_r - CW'(2)) : IW'(sh_r - CW'(1));
  end

  logic no_join;
  logic jp, jn, has_next, ovl;
  always_comb begin
    has_next = found_r;
    jp = has_prev_r && (prev_top_r == {1'b0, addr_r});
    jn = has_next && (end_r == {1'b0, e_start});
    no_join = !jp && !jn;
    ovl = (has_prev_r && prev_top_r > {1'b0, addr_r}) ||
          (has_next && end_r > {1'b0, e_start});
  end

  always_comb begin
    st.scan_end = found_r || bad_r || (idx_r >= count_r) || (idx_r >= SLOTS);
    st.need_shl = 1'b0;
    st.need_shr = 1'b0;
    if (!bad_r && cmd_r == CMD_ALLOC && found_r && {1'b0, e_len} == need_r &&
        (idx_r + CW'(1) < count_r))
      st.need_shl = 1'b1;
    if (!bad_r && cmd_r == CMD_FREE && !ovl && jp && jn && (idx_r + CW'(1) < count_r))
      st.need_shl = 1'b1;
    if (!bad_r && cmd_r == CMD_FREE && !ovl && no_join && count_r < SLOTS &&
        idx_r < count_r)
      st.need_shr = 1'b1;
    st.shift_end = rd_v_r && (ctl.shl ? (sh_r >= count_r) : (sh_r == pos_r));
    st.bad_early = bad_r || cmd_r == CMD_INIT;
  end

  always_comb begin
    we = 1'b0; waddr = '0; wdata = '0;
    if (ctl.clr && cmd_r == CMD_INIT) begin
      we = 1'b1; wdata = {heap_base, 1'b0, heap_size};
    end
    if (ctl.decide && !bad_r) begin
      waddr = idx_r[IW-1:0];
      if (cmd_r == CMD_ALLOC && found_r && {1'b0, e_len} != need_r) begin
        we = 1'b1; wdata = {32'(e_start + need_r[31:0]), 32'(e_len - need_r[31:0])};
      end
      if (cmd_r == CMD_FREE && !ovl && !(no_join && count_r >= SLOTS)) begin
        if (jp) begin
          we = 1'b1; waddr = IW'(idx_r - CW'(1));
          wdata = {32'(prev_top_r[31:0] - prev_len_r),
                   32'(prev_len_r + need_r[31:0] + (jn ? e_len : 32'd0))};
        end else if (jn) begin
          we = 1'b1; wdata = {addr_r, 32'(e_len + need_r[31:0])};
        end else if (idx_r >= count_r) begin
          we = 1'b1; wdata = {addr_r, need_r[31:0]};
        end
      end
    end
    if (ctl.shl && rd_v_r) begin
      we = 1'b1; waddr = IW'(sh_r - CW'(1)); wdata = rdata_r;
    end
    if (ctl.shr && rd_v_r) begin
      we = 1'b1; waddr = sh_r[IW-1:0]; wdata = (sh_r == pos_r) ? carry_r : rdata_r;
    end
    // whole-heap extent at reset
    if (!rst_n) begin
      we = 1'b1; waddr = '0; wdata = {32'd0, HEAP_SIZE_RESET};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CW'(1);
      free_r <= HEAP_SIZE_RESET;
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= 1'b0;
      if (ctl.load) begin
        cmd_r <= cmd; addr_r <= address; need_r <= round8;
        end_r <= 33'({1'b0, address} + round8);
        idx_r <= '0; found_r <= 1'b0; has_prev_r <= 1'b0;
        blk_r <= '0; stat_r <= ST_OK; bad_r <= 1'b0;
        if (cmd != CMD_INIT && cmd != CMD_ALLOC && cmd != CMD_FREE) begin
          bad_r <= 1'b1; stat_r <= ST_BAD;
        end else if (cmd != CMD_INIT && size_bytes == 32'd0) begin
          bad_r <= 1'b1; stat_r <= ST_ZERO;
        end else if (cmd == CMD_FREE &&
                     (address < heap_base ||
                      {1'b0, address} + {1'b0, round8} > heap_top)) begin
          bad_r <= 1'b1; stat_r <= ST_BAD;
        end
      end
      if (ctl.clr && cmd_r == CMD_INIT) begin
        count_r <= (heap_size != 31'd0) ? CW'(1) : '0;
        free_r <= {1'b0, heap_size};
      end
      if (ctl.rd && !st.scan_end) begin
        // rdata_r holds entry idx_r
        if (cmd_r == CMD_ALLOC) begin
          if ({1'b0, e_len} >= need_r) found_r <= 1'b1;
          else idx_r <= idx_r + CW'(1);
        end else begin
          if (e_start >= addr_r) found_r <= 1'b1;
          else begin
            idx_r <= idx_r + CW'(1); has_prev_r <= 1'b1;
            prev_top_r <= {1'b0, e_start} + {1'b0, e_len};
            prev_len_r <= e_len;
          end
        end
      end
      if (ctl.decide) begin
        pos_r <= idx_r;
        if (!bad_r && cmd_r == CMD_ALLOC) begin
          if (!found_r) stat_r <= ST_NOFIT;
          else begin
            blk_r <= e_start;
            free_r <= 32'(free_r - need_r[31:0]);
            if ({1'b0, e_len} == need_r) count_r <= count_r - CW'(1);
          end
        end
        if (!bad_r && cmd_r == CMD_FREE) begin
          if (ovl) stat_r <= ST_BAD;
          else if (no_join && count_r >= SLOTS) stat_r <= ST_FULL;
          else begin
            free_r <= 32'(free_r + need_r[31:0]);
            if (jp && jn) count_r <= count_r - CW'(1);
            else if (no_join) count_r <= count_r + CW'(1);
          end
        end
        // shift cursors
        sh_r <= idx_r + CW'(1);
        if (!bad_r && cmd_r == CMD_FREE && no_join) begin
          sh_r <= count_r;
          carry_r <= {addr_r, need_r[31:0]};
        end
      end
      if (ctl.shl) begin
        rd_v_r <= 1'b1;
        if (rd_v_r) sh_r <= sh_r + CW'(1);
      end
      if (ctl.shr) begin
        rd_v_r <= 1'b1;
        if (rd_v_r) sh_r <= sh_r - CW'(1);
      end
    end
  end

  // overlap is checked in decide; bad results skip shifting via need flags
  always_comb begin
    status = stat_r;
    block_address = blk_r;
    free_bytes = free_r;
  end
endmodule

// ===== src/first_fit_heap_allocator_top.sv =====
// top level of the first-fit heap allocator
// depends on ffha_pkg, ffha_ctrl, ffha_dp
// Each command passes the clear state (init and bad commands then go straight
// to done), a scan and a read state per extent scanned, the decide state, the
// shift steps when the table is shifted, and the done state; the extent memory
// read is registered, hence a scan and a read state per extent. busy stays
// high until the result beat, which out_valid marks for one cycle and which
// the receiver cannot stall; the next command can be accepted in that cycle.
module first_fit_heap_allocator_top #(
  parameter int FREE_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_size_bytes,
  input  logic [31:0] in_address,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_block_address,
  output logic [31:0] out_free_bytes,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ffha_pkg::*;

  ctrl_t ctl;
  stat_t st;
  logic [31:0] cfg_heap_base_r;
  logic [30:0] cfg_heap_size_r;
  logic        out_valid_r;

  // config registers at byte 0 and 4
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_heap_base_r <= '0;
      cfg_heap_size_r <= HEAP_SIZE_RESET[30:0];
    end else if (psel && penable && pwrite) begin
      if (paddr == 3'd0) cfg_heap_base_r <= pwdata;
      if (paddr == 3'd4) cfg_heap_size_r <= pwdata[30:0];
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? cfg_heap_base_r :
                  (paddr == 3'd4) ? {1'b0, cfg_heap_size_r} : 32'd0;

  ffha_ctrl u_ctrl (.clk, .rst_n, .start, .st, .ctl, .busy);

  ffha_dp #(.FREE_SLOTS(FREE_SLOTS)) u_dp (
    .clk, .rst_n, .ctl,
    .cmd(in_cmd), .size_bytes(in_size_bytes), .address(in_address),
    .heap_base(cfg_heap_base_r), .heap_size(cfg_heap_size_r),
    .st, .status(out_status), .block_address(out_block_address),
    .free_bytes(out_free_bytes)
  );

  // result beat in the cycle after the done state
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= ctl.done;
  end
  assign out_valid = out_valid_r;
endmodule

// ===== src/ffha_checker.sv =====
// port-level checker for the heap allocator, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
module ffha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic [31:0] out_block_address
);
  `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `ASSERT_NEXT(a_one_beat, clk, rst_n, out_valid, !out_valid)
  `ASSERT_IMPL(a_blk_zero, clk, rst_n, out_valid && out_status != 3'd0 || 1'b0, out_block_address == 32'd0 || out_status == 3'd0)
  `ASSERT_IMPL(a_status_rng, clk, rst_n, out_valid, out_status <= 3'd4)
endmodule

bind first_fit_heap_allocator_top ffha_checker u_chk (
  .clk, .rst_n, .start, .busy, .out_valid, .out_status, .out_block_address
);

// ===== test/first_fit_heap_allocator_top_test.sv =====
// testbench for first_fit_heap_allocator_top: directed and random commands checked
// against an in-bench prediction of the free-extent table
// depends on ffha_pkg and the allocator rtl
`timescale 1ns / 100ps

module first_fit_heap_allocator_top_test;
  import ffha_pkg::*;

  localparam int SLOTS       = 64;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_WAIT  = 4 * SLOTS + 40;  // worst command latency plus margin
  localparam logic [2:0] ADDR_BASE = 3'd0;
  localparam logic [2:0] ADDR_SIZE = 3'd4;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] block_address;
    logic [31:0] free_bytes;
  } heap_result_t;

  typedef struct {
    logic [31:0] addr;
    logic [31:0] len;
  } live_block_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_cmd;
  logic [31:0] in_size_bytes;
  logic [31:0] in_address;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [31:0] out_block_address;
  logic [31:0] out_free_bytes;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predicted allocator state
  logic [31:0] ext_start [SLOTS];
  logic [31:0] ext_len [SLOTS];
  int unsigned ext_count;
  logic [31:0] free_sum;
  logic [31:0] base_reg;
  logic [30:0] size_reg;

  heap_result_t expected_results[$];
  live_block_t  live_blocks[$];
  int           error_count;
  int           cycle_count;
  int           gap_pct;

  first_fit_heap_allocator_top #(.FREE_SLOTS(SLOTS)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_size_bytes(in_size_bytes), .in_address(in_address),
    .out_valid(out_valid), .out_status(out_status),
    .out_block_address(out_block_address), .out_free_bytes(out_free_bytes),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  // ---------------------------------------------------------------- prediction
  function automatic void clear_table();
    for (int j = 0; j < SLOTS; j++) begin
      ext_start[j] = '0;
      ext_len[j] = '0;
    end
    if (size_reg != 0) begin
      ext_start[0] = base_reg;
      ext_len[0] = {1'b0, size_reg};
      ext_count = 1;
    end else begin
      ext_count = 0;
    end
    free_sum = {1'b0, size_reg};
  endfunction

  function automatic logic [63:0] round_up8(logic [31:0] n);
    return ({32'd0, n} + 64'd7) & ~64'd7;
  endfunction

  function automatic void drop_extent(int unsigned idx);
    for (int unsigned j = idx; j + 1 < ext_count; j++) begin
      ext_start[j] = ext_start[j + 1];
      ext_len[j] = ext_len[j + 1];
    end
    ext_count--;
  endfunction

  function automatic logic [2:0] predict_alloc(logic [31:0] sz, output logic [31:0] blk);
    logic [63:0] need;
    blk = '0;
    if (sz == 0) return ST_ZERO;
    need = round_up8(sz);
    for (int unsigned i = 0; i < ext_count; i++) begin
      if ({32'd0, ext_len[i]} >= need) begin
        blk = ext_start[i];
        if ({32'd0, ext_len[i]} == need) begin
          drop_extent(i);
        end else begin
          ext_start[i] = ext_start[i] + need[31:0];
          ext_len[i] = ext_len[i] - need[31:0];
        end
        free_sum = free_sum - need[31:0];
        return ST_OK;
      end
    end
    return ST_NOFIT;
  endfunction

  function automatic logic [2:0] predict_free(logic [31:0] sz, logic [31:0] addr);
    logic [63:0] n;
    logic [63:0] blk_end;
    logic [63:0] prev_top;
    int unsigned i;
    bit has_prev;
    bit has_next;
    bit join_prev;
    bit join_next;
    if (sz == 0) return ST_ZERO;
    n = round_up8(sz);
    blk_end = {32'd0, addr} + n;
    if (addr < base_reg || blk_end > {32'd0, base_reg} + {33'd0, size_reg}) return ST_BAD;
    i = 0;
    while (i < ext_count && ext_start[i] < addr) i++;
    has_prev = (i > 0);
    has_next = (i < ext_count);
    prev_top = has_prev ? {32'd0, ext_start[i - 1]} + {32'd0, ext_len[i - 1]} : 64'd0;
    if ((has_prev && prev_top > {32'd0, addr}) ||
        (has_next && blk_end > {32'd0, ext_start[i]})) return ST_BAD;
    join_prev = has_prev && prev_top == {32'd0, addr};
    join_next = has_next && blk_end == {32'd0, ext_start[i]};
    if (!join_prev && !join_next) begin
      if (ext_count >= SLOTS) return ST_FULL;
      for (int unsigned j = ext_count; j > i; j--) begin
        ext_start[j] = ext_start[j - 1];
        ext_len[j] = ext_len[j - 1];
      end
      ext_start[i] = addr;
      ext_len[i] = n[31:0];
      ext_count++;
    end else if (join_prev && join_next) begin
      ext_len[i - 1] = ext_len[i - 1] + n[31:0] + ext_len[i];
      drop_extent(i);
    end else if (join_prev) begin
      ext_len[i - 1] = ext_len[i - 1] + n[31:0];
    end else begin
      ext_start[i] = addr;
      ext_len[i] = ext_len[i] + n[31:0];
    end
    free_sum = free_sum + n[31:0];
    return ST_OK;
  endfunction

  function automatic heap_result_t predict_command(logic [1:0] cmd, logic [31:0] sz,
                                                   logic [31:0] addr);
    heap_result_t r;
    r.block_address = '0;
    case (cmd)
      CMD_INIT: begin
        clear_table();
        live_blocks.delete();
        r.status = ST_OK;
      end
      CMD_ALLOC: begin
        r.status = predict_alloc(sz, r.block_address);
        if (r.status == ST_OK)
          live_blocks.push_back('{r.block_address, 32'(round_up8(sz))});
      end
      CMD_FREE: r.status = predict_free(sz, addr);
      default: r.status = ST_BAD;
    endcase
    r.free_bytes = free_sum;
    return r;
  endfunction

  // ---------------------------------------------------------------- result checker
  always @(posedge clk) begin
    heap_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", {29'd0, out_status}, 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", {29'd0, out_status}, {29'd0, want.status});
        if (out_block_address !== want.block_address)
          report_mismatch("block_address", out_block_address, want.block_address);
        if (out_free_bytes !== want.free_bytes)
          report_mismatch("free_bytes", out_free_bytes, want.free_bytes);
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  // one command beat; a gap idles start once the block is free again
  task automatic send_command(input logic [1:0] cmd, input logic [31:0] sz,
                              input logic [31:0] addr);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while (busy) @(posedge clk);
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_size_bytes <= sz;
    in_address <= addr;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(predict_command(cmd, sz, addr));
  endtask

  // wait until every result beat has come and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // register written at this edge
    if (addr == ADDR_BASE) base_reg = data;
    else size_reg = data[30:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_heap(input logic [31:0] base, input logic [31:0] len);
    drain();
    write_register(ADDR_BASE, base);
    write_register(ADDR_SIZE, len);
  endtask

  // ---------------------------------------------------------------- tests
  // ops, rounding, the no-join, join-above and join-both merges and the zero, bad and no-fit paths on the reset heap
  task automatic test_basic_ops();
    send_command(CMD_INIT, 32'd0, 32'd0);
    send_command(CMD_ALLOC, 32'd0, 32'd0);           // zero size
    send_command(CMD_ALLOC, 32'd1, 32'hFFFF_FFFF);    // rounds to 8
    send_command(CMD_ALLOC, 32'd16, 32'd0);
    send_command(CMD_ALLOC, 32'd21, 32'd0);           // rounds to 24
    send_command(CMD_FREE, 32'd16, 32'd8);            // no neighbour joins
    send_command(CMD_FREE, 32'd8, 32'd0);             // joins the extent above
    send_command(CMD_FREE, 32'd24, 32'd24);           // joins both sides
    send_command(CMD_FREE, 32'd8, 32'd0);             // overlaps free space
    send_command(CMD_FREE, 32'd0, 32'd64);            // zero size
    send_command(CMD_FREE, 32'hFFFF_FFFF, 32'd0);     // rounds past 32 bits
    send_command(CMD_ALLOC, 32'hFFFF_FFF9, 32'd0);    // rounds past 32 bits
    send_command(CMD_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send_command(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(CMD_ALLOC, 32'd16, 32'd0);
    send_command(CMD_FREE, 32'd16, 32'd8);            // overlaps the extent above
    send_command(CMD_FREE, 32'd8, 32'd0);             // no neighbour joins
    send_command(CMD_FREE, 32'd8, 32'd8);             // joins both sides
    send_command(CMD_ALLOC, HEAP_SIZE_RESET, 32'd0);  // exact fit empties the table
    send_command(CMD_ALLOC, 32'd8, 32'd0);            // no fit
    send_command(CMD_FREE, 32'd8, HEAP_SIZE_RESET);   // past the heap end
    send_command(CMD_FREE, HEAP_SIZE_RESET, 32'd0);   // into an empty table
  endtask

  // register extremes, empty heap and register changes without init
  task automatic test_heap_config();
    set_heap(32'hFFFF_FFF8, 32'd8);
    send_command(CMD_INIT, 32'd0, 32'd0);
    send_command(CMD_ALLOC, 32'd8, 32'd0);
    send_command(CMD_FREE, 32'd8, 32'd0);             // below the base
    send_command(CMD_FREE, 32'd8, 32'hFFFF_FFF8);
    set_heap(32'd0, 32'd0);
    send_command(CMD_INIT, 32'd0, 32'd0);             // empty heap
    send_command(CMD_ALLOC, 32'd8, 32'd0);
    send_command(CMD_FREE, 32'd8, 32'd0);
    set_heap(32'h8000_0000, 32'h7FFF_FFF8);
    send_command(CMD_INIT, 32'd0, 32'd0);
    send_command(CMD_ALLOC, 32'h7FFF_FFF8, 32'd0);
    send_command(CMD_FREE, 32'h7FFF_FFF8, 32'h8000_0000);
    send_command(CMD_ALLOC, 32'd40, 32'd0);
    // new registers but no init: the old table stays
    set_heap(32'h7FFF_FF00, 32'h7FFF_FFFF);
    send_command(CMD_FREE, 32'd40, 32'h8000_0000);
    send_command(CMD_FREE, 32'd8, 32'h7FFF_FF00);
    send_command(CMD_ALLOC, 32'd16, 32'd0);
  endtask

  // fill the table with isolated extents until it reports full
  task automatic test_table_full();
    set_heap(32'h0000_1000, 32'd1032);
    send_command(CMD_INIT, 32'd0, 32'd0);
    for (int k = 0; k < 129; k++) send_command(CMD_ALLOC, 32'd8, 32'd0);
    for (int k = 0; k < 128; k += 2) send_command(CMD_FREE, 32'd8, 32'h1000 + 8 * k);
    send_command(CMD_FREE, 32'd8, 32'h1000 + 8 * 128);  // table full
    send_command(CMD_FREE, 32'd8, 32'h1000 + 8);        // joins both sides
    send_command(CMD_FREE, 32'd8, 32'h1000 + 8 * 128);  // room again
  endtask

  // mostly alloc/free of live blocks, some init and malformed commands
  task automatic test_random_traffic(input int count);
    int pick;
    int idx;
    live_block_t b;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_command(CMD_ALLOC, ($urandom_range(9) == 0) ? $urandom_range(1, 1024)
                                                         : $urandom_range(1, 96), $urandom);
      end else if (pick < 80 && live_blocks.size() != 0) begin
        idx = $urandom_range(live_blocks.size() - 1);
        b = live_blocks[idx];
        live_blocks.delete(idx);
        // a partial size still frees the whole rounded tail sometimes
        send_command(CMD_FREE, ($urandom_range(3) == 0) ? b.len - $urandom_range(0, 7)
                                                        : b.len, b.addr);
      end else if (pick < 83) begin
        send_command(CMD_INIT, $urandom, $urandom);
      end else if (pick < 88) begin
        send_command(CMD_UNUSED, $urandom, $urandom);
      end else if (pick < 92) begin
        send_command(2'($urandom_range(1, 2)), 32'd0, $urandom);
      end else if (pick < 96) begin
        send_command(CMD_FREE, $urandom, $urandom);
      end else begin
        send_command(CMD_ALLOC, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_INIT;
    in_size_bytes = '0;
    in_address = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    error_count = 0;
    cycle_count = 0;
    gap_pct = 0;
    base_reg = '0;
    size_reg = HEAP_SIZE_RESET[30:0];
    clear_table();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_heap_config();
    test_table_full();

    // random phases: no idling, heavy sender gaps, none again, light gaps
    set_heap(32'h0001_0000, 32'd4096);
    gap_pct = 0;
    send_command(CMD_INIT, 32'd0, 32'd0);
    test_random_traffic(120);
    set_heap(32'hFFFF_E000, 32'd8192);
    gap_pct = 72;
    send_command(CMD_INIT, 32'd0, 32'd0);
    test_random_traffic(120);
    set_heap(32'd0, HEAP_SIZE_RESET);
    gap_pct = 0;
    send_command(CMD_INIT, 32'd0, 32'd0);
    test_random_traffic(120);
    set_heap(32'h4000_0008, 32'd1536);
    gap_pct = 14;
    send_command(CMD_INIT, 32'd0, 32'd0);
    test_random_traffic(120);

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+src
src/ffha_pkg.sv
src/ffha_ctrl.sv
src/ffha_dp.sv
src/first_fit_heap_allocator_top.sv
src/ffha_checker.sv
test/first_fit_heap_allocator_top_test.sv
